// File: rtl/led_dimmer_fade_ack_flash_defines.svh
// Assertion macros used by the checker file of the LED dimmer.
`ifndef LED_DIMMER_FADE_ACK_FLASH_DEFINES_SVH
`define LED_DIMMER_FADE_ACK_FLASH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ldf_pkg.sv
// Package with the constants, codes and control types of the LED dimmer.
package ldf_pkg;

    localparam int LevelW  = 7;
    localparam int Q8W     = 15;
    localparam int TimeW   = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    localparam logic [LevelW-1:0] LevelMax      = 7'd100;
    localparam logic [LevelW-1:0] MemoryMin     = 7'd10;
    localparam logic [LevelW-1:0] FlashLevelMin = 7'd34;
    localparam logic [LevelW-1:0] FlashLift     = 7'd24;
    localparam logic [LevelW-1:0] FlashDrop     = 7'd22;
    localparam logic [7:0]        FlashMaxCount = 8'd4;
    localparam logic [LevelW-1:0] MemoryReset   = 7'd65;

    localparam logic [15:0] PwmTopReset     = 16'd1000;
    localparam logic [14:0] FadeStepReset   = 15'd640;
    localparam logic [7:0]  TickPeriodReset = 8'd4;
    localparam logic [15:0] FlashHighReset  = 16'd70;
    localparam logic [15:0] FlashLowReset   = 16'd50;

    // Curve arithmetic: the rounded product is divided by 10000 as a shift by four
    // and a reciprocal multiply for the division by 625, exact over the whole
    // product range.
    localparam int QuotW      = 16;
    localparam int RemW       = 30;
    localparam int CurveShift = 4;
    localparam int DivNumW    = RemW - CurveShift;
    localparam int RecipW     = 27;
    localparam int RecipShift = 36;
    localparam int DivProdW   = DivNumW + RecipW;
    localparam int CurveRound = 5000;
    localparam logic [RecipW-1:0] RecipMul = 27'd109951163;

    // Command codes.
    localparam logic [3:0] MODE_TICK      = 4'd0;
    localparam logic [3:0] MODE_SET_TGT   = 4'd1;
    localparam logic [3:0] MODE_ADD_TGT   = 4'd2;
    localparam logic [3:0] MODE_ON        = 4'd3;
    localparam logic [3:0] MODE_OFF       = 4'd4;
    localparam logic [3:0] MODE_TOGGLE    = 4'd5;
    localparam logic [3:0] MODE_SET_NOW   = 4'd6;
    localparam logic [3:0] MODE_SET_MEM   = 4'd7;
    localparam logic [3:0] MODE_ADD_MEM   = 4'd8;
    localparam logic [3:0] MODE_FLASH     = 4'd9;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_PWM_TOP     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FADE_STEP   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TICK_PERIOD = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FLASH_HIGH  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_FLASH_LOW   = 3'd4;

    typedef struct packed {
        logic capture;
        logic exec;
        logic ramp;
        logic square;
        logic mul;
        logic div;
        logic load;
    } ldf_cmd_t;

endpackage

// File: rtl/ldf_ctrl.sv
// Sequencer of the LED dimmer: walks each transaction through the datapath steps.
module ldf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    output logic                  res_valid,
    input  logic                  res_stall,
    output ldf_pkg::ldf_cmd_t     ctl_cmd
);
    import ldf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_RAMP   = 3'd2;
    localparam logic [2:0] S_SQUARE = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_LOAD   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl_cmd    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl_cmd.capture = 1'b1;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl_cmd.exec = 1'b1;
                state_next   = S_RAMP;
            end
            S_RAMP:
            begin
                ctl_cmd.ramp = 1'b1;
                state_next   = S_SQUARE;
            end
            S_SQUARE:
            begin
                ctl_cmd.square = 1'b1;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                ctl_cmd.mul = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                ctl_cmd.div = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                // The result register is free or is emptied in this cycle.
                if (!res_valid_reg || !res_stall)
                begin
                    ctl_cmd.load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctl_cmd.load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

// File: rtl/ldf_datapath.sv
// Datapath of the LED dimmer: settings, level state, fade ramp, flash and PWM curve.
module ldf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ldf_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ldf_pkg::CfgDataW-1:0]  cfg_data,
    input  logic [3:0]                    mode,
    input  logic [31:0]                   now_ms,
    input  logic [7:0]                    level,
    input  logic signed [7:0]             step,
    input  logic [7:0]                    flash_count,
    input  ldf_pkg::ldf_cmd_t             ctl_cmd,
    output logic [15:0]                   pwm_compare,
    output logic                          pwm_written,
    output logic [6:0]                    brightness,
    output logic [6:0]                    target,
    output logic [6:0]                    memory_level,
    output logic                          is_on
);
    import ldf_pkg::*;

    // Settings.
    logic [15:0] pwm_top_reg;
    logic [14:0] fade_step_reg;
    logic [7:0]  tick_period_reg;
    logic [15:0] flash_high_reg;
    logic [15:0] flash_low_reg;

    // Captured transaction.
    logic [3:0]        mode_reg;
    logic [TimeW-1:0]  now_reg;
    logic [7:0]        level_reg;
    logic signed [7:0] step_reg;
    logic [7:0]        count_reg;

    // Dimmer state.
    logic [LevelW-1:0] remembered_reg, remembered_next;
    logic [LevelW-1:0] base_reg, base_next;
    logic [Q8W-1:0]    cur_reg, cur_next;
    logic [TimeW-1:0]  last_reg, last_next;
    logic              flash_active_reg, flash_active_next;
    logic              flash_bright_reg, flash_bright_next;
    logic [3:0]        edges_reg, edges_next;
    logic [TimeW-1:0]  flash_time_reg, flash_time_next;

    // Work registers.
    logic [LevelW-1:0] ft_reg, ft_next;
    logic              tick_due_reg, tick_due_next;
    logic              written_reg, written_next;
    logic [LevelW-1:0] lvl_reg, lvl_next;
    logic [13:0]       sq_reg, sq_next;
    logic [RemW-1:0]   rem_reg, rem_next;
    logic [QuotW-1:0]  quot_reg, quot_next;

    // Result register.
    logic [15:0]       pwm_compare_reg;
    logic              pwm_written_reg;
    logic [LevelW-1:0] brightness_reg;
    logic [LevelW-1:0] target_reg;
    logic [LevelW-1:0] memory_reg;
    logic              is_on_reg;

    function automatic logic [LevelW-1:0] clamp_level(input logic signed [8:0] v,
                                                       input logic [LevelW-1:0] lo);
        logic [LevelW-1:0] r;
        if (v < $signed({2'b00, lo}))
        begin
            r = lo;
        end
        else if (v > $signed({2'b00, LevelMax}))
        begin
            r = LevelMax;
        end
        else
        begin
            r = v[LevelW-1:0];
        end
        return r;
    endfunction

    // Command operands.
    logic [LevelW-1:0] lvl_clamped;
    logic signed [8:0] tgt_sum;
    logic signed [8:0] mem_sum;
    logic [LevelW-1:0] mem_on;
    logic [3:0]        edges_start;

    assign lvl_clamped = (level_reg > {1'b0, LevelMax}) ? LevelMax : level_reg[LevelW-1:0];
    assign tgt_sum     = $signed({2'b00, base_reg}) + $signed({step_reg[7], step_reg});
    assign mem_sum     = $signed({2'b00, remembered_reg}) + $signed({step_reg[7], step_reg});
    assign mem_on      = (remembered_reg < MemoryMin) ? MemoryMin : remembered_reg;
    assign edges_start = (count_reg > FlashMaxCount) ? {FlashMaxCount[2:0], 1'b0}
                                                     : {count_reg[2:0], 1'b0};

    // Tick timing and flash sequence.
    logic [TimeW-1:0]  elapsed;
    logic              tick_due;
    logic [TimeW-1:0]  flash_diff;
    logic              flash_edge;
    logic              bright_new;
    logic [3:0]        edges_dec;
    logic              flash_end;
    logic [TimeW-1:0]  flash_time_new;
    logic [LevelW-1:0] lift_level;
    logic [LevelW-1:0] drop_level;
    logic [LevelW-1:0] flash_tgt;

    assign elapsed        = now_reg - last_reg;
    assign tick_due       = (elapsed >= {24'd0, tick_period_reg});
    assign flash_diff     = now_reg - flash_time_reg;
    assign flash_edge     = flash_active_reg && !flash_diff[TimeW-1];
    assign bright_new     = flash_edge ? !flash_bright_reg : flash_bright_reg;
    assign edges_dec      = (edges_reg != 4'd0) ? edges_reg - 4'd1 : 4'd0;
    assign flash_end      = flash_edge && (edges_dec == 4'd0);
    assign flash_time_new = now_reg + (bright_new ? {16'd0, flash_high_reg}
                                                  : {16'd0, flash_low_reg});

    always_comb
    begin
        if (base_reg < FlashLevelMin)
        begin
            lift_level = FlashLevelMin;
        end
        else if (base_reg + FlashLift < LevelMax)
        begin
            lift_level = base_reg + FlashLift;
        end
        else
        begin
            lift_level = LevelMax;
        end
    end

    assign drop_level = (base_reg > FlashDrop) ? base_reg - FlashDrop : '0;
    assign flash_tgt  = (!flash_active_reg || flash_end) ? base_reg
                      : (bright_new ? lift_level : drop_level);

    // Fade ramp.
    logic [Q8W-1:0] tq8;
    logic           ramp_up;
    logic [Q8W-1:0] ramp_diff;

    assign tq8       = {ft_reg, 8'd0};
    assign ramp_up   = (cur_reg < tq8);
    assign ramp_diff = ramp_up ? tq8 - cur_reg : cur_reg - tq8;

    // Curve arithmetic.
    logic [Q8W-1:0]      cur_round;
    logic [LevelW-1:0]   cur_level;
    logic [15:0]         top_m1;
    logic [RemW-1:0]     curve_prod;
    logic [DivNumW-1:0]  div_num;
    logic [DivProdW-1:0] div_prod;
    logic [QuotW-1:0]    pwm_raw;
    logic [15:0]         pwm_value;

    assign cur_round  = cur_reg + 15'd128;
    assign cur_level  = cur_round[Q8W-1:8];
    assign top_m1     = pwm_top_reg - 16'd1;
    assign curve_prod = {16'd0, sq_reg} * {14'd0, top_m1};
    assign div_num    = rem_reg[RemW-1:CurveShift];
    assign div_prod   = {{RecipW{1'b0}}, div_num} * {{DivNumW{1'b0}}, RecipMul};
    assign pwm_raw    = quot_reg + 16'd1;
    assign pwm_value  = (lvl_reg == '0 || pwm_top_reg == 16'd0) ? 16'd0
                      : ((pwm_raw > pwm_top_reg) ? pwm_top_reg : pwm_raw);

    always_comb
    begin
        remembered_next   = remembered_reg;
        base_next         = base_reg;
        cur_next          = cur_reg;
        last_next         = last_reg;
        flash_active_next = flash_active_reg;
        flash_bright_next = flash_bright_reg;
        edges_next        = edges_reg;
        flash_time_next   = flash_time_reg;
        ft_next           = ft_reg;
        tick_due_next     = tick_due_reg;
        written_next      = written_reg;
        lvl_next          = lvl_reg;
        sq_next           = sq_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;

        if (ctl_cmd.exec)
        begin
            tick_due_next = 1'b0;
            written_next  = 1'b0;
            unique case (mode_reg)
                MODE_TICK:
                begin
                    if (tick_due)
                    begin
                        last_next     = now_reg;
                        ft_next       = flash_tgt;
                        tick_due_next = 1'b1;
                        if (flash_edge)
                        begin
                            flash_bright_next = bright_new;
                            edges_next        = edges_dec;
                            if (flash_end)
                            begin
                                flash_active_next = 1'b0;
                            end
                            else
                            begin
                                flash_time_next = flash_time_new;
                            end
                        end
                    end
                end
                MODE_SET_TGT, MODE_SET_NOW:
                begin
                    base_next = lvl_clamped;
                    if (lvl_clamped > MemoryMin)
                    begin
                        remembered_next = lvl_clamped;
                    end
                    if (mode_reg == MODE_SET_NOW)
                    begin
                        cur_next     = {lvl_clamped, 8'd0};
                        written_next = 1'b1;
                    end
                end
                MODE_ADD_TGT:
                begin
                    base_next = clamp_level(tgt_sum, '0);
                    if (clamp_level(tgt_sum, '0) > MemoryMin)
                    begin
                        remembered_next = clamp_level(tgt_sum, '0);
                    end
                end
                MODE_ON:
                begin
                    remembered_next = mem_on;
                    base_next       = mem_on;
                end
                MODE_OFF:
                begin
                    base_next = '0;
                end
                MODE_TOGGLE:
                begin
                    if (base_reg == '0)
                    begin
                        remembered_next = mem_on;
                        base_next       = mem_on;
                    end
                    else
                    begin
                        base_next = '0;
                    end
                end
                MODE_SET_MEM:
                begin
                    remembered_next = clamp_level($signed({1'b0, level_reg}), MemoryMin);
                end
                MODE_ADD_MEM:
                begin
                    remembered_next = clamp_level(mem_sum, MemoryMin);
                end
                MODE_FLASH:
                begin
                    if (count_reg != 8'd0)
                    begin
                        flash_active_next = 1'b1;
                        flash_bright_next = 1'b1;
                        edges_next        = edges_start;
                        flash_time_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctl_cmd.ramp && tick_due_reg && (cur_reg != tq8))
        begin
            written_next = 1'b1;
            if (ramp_diff <= fade_step_reg)
            begin
                cur_next = tq8;
            end
            else if (ramp_up)
            begin
                cur_next = cur_reg + fade_step_reg;
            end
            else
            begin
                cur_next = cur_reg - fade_step_reg;
            end
        end

        if (ctl_cmd.square)
        begin
            lvl_next = cur_level;
            sq_next  = {7'd0, cur_level} * {7'd0, cur_level};
        end

        if (ctl_cmd.mul)
        begin
            rem_next = curve_prod + RemW'(CurveRound);
        end

        // Dividing by 16 first leaves a division by 625, which the reciprocal
        // multiply gives exactly for every numerator below 2^26.
        if (ctl_cmd.div)
        begin
            quot_next = div_prod[RecipShift +: QuotW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_top_reg      <= PwmTopReset;
            fade_step_reg    <= FadeStepReset;
            tick_period_reg  <= TickPeriodReset;
            flash_high_reg   <= FlashHighReset;
            flash_low_reg    <= FlashLowReset;
            remembered_reg   <= MemoryReset;
            base_reg         <= '0;
            cur_reg          <= '0;
            last_reg         <= '0;
            flash_active_reg <= 1'b0;
            flash_bright_reg <= 1'b0;
            edges_reg        <= '0;
            flash_time_reg   <= '0;
            tick_due_reg     <= 1'b0;
            written_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PWM_TOP:     pwm_top_reg     <= cfg_data;
                    CFG_FADE_STEP:   fade_step_reg   <= cfg_data[14:0];
                    CFG_TICK_PERIOD: tick_period_reg <= cfg_data[7:0];
                    CFG_FLASH_HIGH:  flash_high_reg  <= cfg_data;
                    CFG_FLASH_LOW:   flash_low_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            remembered_reg   <= remembered_next;
            base_reg         <= base_next;
            cur_reg          <= cur_next;
            last_reg         <= last_next;
            flash_active_reg <= flash_active_next;
            flash_bright_reg <= flash_bright_next;
            edges_reg        <= edges_next;
            flash_time_reg   <= flash_time_next;
            tick_due_reg     <= tick_due_next;
            written_reg      <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.capture)
        begin
            mode_reg  <= mode;
            now_reg   <= now_ms;
            level_reg <= level;
            step_reg  <= step;
            count_reg <= flash_count;
        end
        ft_reg   <= ft_next;
        lvl_reg  <= lvl_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (ctl_cmd.load)
        begin
            pwm_compare_reg <= pwm_value;
            pwm_written_reg <= written_reg;
            brightness_reg  <= lvl_reg;
            target_reg      <= base_reg;
            memory_reg      <= remembered_reg;
            is_on_reg       <= (base_reg != '0);
        end
    end

    assign pwm_compare  = pwm_compare_reg;
    assign pwm_written  = pwm_written_reg;
    assign brightness   = brightness_reg;
    assign target       = target_reg;
    assign memory_level = memory_reg;
    assign is_on        = is_on_reg;

endmodule

// File: rtl/led_dimmer_fade_ack_flash.sv
// Top level of the LED dimmer with fade ramp and acknowledge flash.
//
//   Channel   Handshake             Payload
//   command   cmd_valid/cmd_stall   mode, now_ms, level, step, flash_count
//   result    res_valid/res_stall   pwm_compare, pwm_written, brightness .. is_on
//   config    cfg_we                cfg_index, cfg_data
//
// One transaction walks through accept, command, ramp, square, multiply,
// reciprocal divide and the result load; the result shows once the load step has run.
// The curve arithmetic runs one step per cycle. A stalled result holds
// the load step until the result register empties; the command side stalls while busy.
// Reset is asynchronous and restores every setting and the dimmer state.
module led_dimmer_fade_ack_flash (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ldf_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ldf_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [3:0]                    mode,
    input  logic [31:0]                   now_ms,
    input  logic [7:0]                    level,
    input  logic signed [7:0]             step,
    input  logic [7:0]                    flash_count,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [15:0]                   pwm_compare,
    output logic                          pwm_written,
    output logic [6:0]                    brightness,
    output logic [6:0]                    target,
    output logic [6:0]                    memory_level,
    output logic                          is_on
);
    import ldf_pkg::*;

    ldf_cmd_t ctl_cmd;

    ldf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .ctl_cmd    (ctl_cmd)
    );

    ldf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .now_ms       (now_ms),
        .level        (level),
        .step         (step),
        .flash_count  (flash_count),
        .ctl_cmd      (ctl_cmd),
        .pwm_compare  (pwm_compare),
        .pwm_written  (pwm_written),
        .brightness   (brightness),
        .target       (target),
        .memory_level (memory_level),
        .is_on        (is_on)
    );

endmodule

// File: rtl/ldf_checker.sv
// Port-level checks of the LED dimmer, bound to the top level.
`include "led_dimmer_fade_ack_flash_defines.svh"

module ldf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [15:0] pwm_compare,
    input logic        pwm_written,
    input logic [6:0]  brightness,
    input logic [6:0]  target,
    input logic [6:0]  memory_level,
    input logic        is_on
);
    import ldf_pkg::*;

    logic [38:0] res_payload;
    logic        res_held;
    logic        levels_ok;

    assign res_payload = {pwm_compare, pwm_written, brightness, target, memory_level, is_on};
    assign res_held    = res_valid && res_stall;
    assign levels_ok   = (brightness <= LevelMax) && (target <= LevelMax)
                      && (memory_level >= MemoryMin) && (memory_level <= LevelMax);

    // A stalled result transaction keeps its payload.
    `LDF_ASSERT_NEXT(a_res_hold, res_held, res_valid && $stable(res_payload), "held result moved")

    `LDF_ASSERT_SAME(a_on_flag, res_valid, is_on == (target != 7'd0), "is_on disagrees with target")

    // Every level stays at or below its maximum, and the remembered level never drops below its floor.
    `LDF_ASSERT_SAME(a_ranges, res_valid, levels_ok, "level out of range")

    `LDF_ASSERT_SAME(a_dark, res_valid && brightness == 7'd0, pwm_compare == 16'd0, "compare not dark")

    // The block works on one command at a time.
    `LDF_ASSERT_NEXT(a_busy, cmd_valid && !cmd_stall, cmd_stall, "command accepted while busy")

endmodule

bind led_dimmer_fade_ack_flash ldf_checker u_checker (.*);
